/* design/ast_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types, constants and character class helpers for the assembly
// source tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

   localparam int POSITION_BITS = 16;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

   typedef logic [POSITION_BITS-1:0] pos_type;

   localparam pos_type POS_ONE = pos_type'(1);
   localparam pos_type POS_MAX = {POSITION_BITS{1'b1}};

   // input item kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOI  = 1'b1;

   // result kinds
   localparam logic RK_BYTE = 1'b0;
   localparam logic RK_END  = 1'b1;

   // characters with a role in the grammar
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   typedef enum logic [3:0] {
      TK_BAD       = 4'd0,
      TK_END       = 4'd1,
      TK_NEWLINE   = 4'd2,
      TK_LBRACKET  = 4'd3,
      TK_RBRACKET  = 4'd4,
      TK_COMMA     = 4'd5,
      TK_DIRECTIVE = 4'd6,
      TK_REGISTER  = 4'd7,
      TK_OFFSET    = 4'd8,
      TK_IMMEDIATE = 4'd9,
      TK_LABEL     = 4'd10,
      TK_IDENT     = 4'd11,
      TK_STRING    = 4'd12
   } tok_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_COMMENT,
      ST_DIR_FIRST,
      ST_DIR_BODY,
      ST_REG_FIRST,
      ST_REG_BODY,
      ST_NAME,
      ST_STR,
      ST_STR_ESC,
      ST_IMM_START,
      ST_IMM_DEC,
      ST_IMM_HEXS,
      ST_IMM_HEXF,
      ST_IMM_HEXB,
      ST_IMM_DONE,
      ST_OFF_START,
      ST_OFF_DEC,
      ST_OFF_HEXS,
      ST_OFF_HEXF,
      ST_OFF_HEXB,
      ST_OFF_DONE,
      ST_FLT_SIGN,
      ST_FLT_FIRST,
      ST_FLT_INT,
      ST_FLT_FRAC
   } scan_state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  value_byte;
      logic [3:0]  token_type;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic        last;
   } rsp_type;

   // results of one input item, first always present
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } bundle_type;

   typedef struct packed {
      logic         open;
      tok_kind_type kind;
   } pend_info_type;

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_xdigit(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
   endfunction

   function automatic pos_type sat_inc(pos_type v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic logic [15:0] clamp_pos(pos_type v);
      logic [POSITION_BITS+15:0] ext;
      ext = (POSITION_BITS+16)'(v);
      if (ext > (POSITION_BITS+16)'(16'hFFFF)) begin
         return 16'hFFFF;
      end
      return ext[15:0];
   endfunction

   function automatic rsp_type mk_byte(logic [7:0] c);
      rsp_type r;
      r = '0;
      r.result_kind = RK_BYTE;
      r.value_byte  = c;
      return r;
   endfunction

   function automatic rsp_type mk_end(tok_kind_type k, pos_type ln, pos_type cl);
      rsp_type r;
      r = '0;
      r.result_kind  = RK_END;
      r.token_type   = k;
      r.start_line   = clamp_pos(ln);
      r.start_column = clamp_pos(cl);
      return r;
   endfunction

   // type the open token would close with right now
   function automatic pend_info_type pending(scan_state_type s);
      pend_info_type p;
      p.open = 1'b1;
      p.kind = TK_BAD;
      case (s)
         ST_IDLE, ST_COMMENT: p.open = 1'b0;
         ST_DIR_BODY: p.kind = TK_DIRECTIVE;
         ST_REG_BODY: p.kind = TK_REGISTER;
         ST_NAME:     p.kind = TK_IDENT;
         ST_FLT_INT, ST_FLT_FRAC, ST_IMM_DEC, ST_IMM_HEXB, ST_IMM_DONE: p.kind = TK_IMMEDIATE;
         ST_OFF_DEC, ST_OFF_HEXB, ST_OFF_DONE: p.kind = TK_OFFSET;
         default: p.kind = TK_BAD;
      endcase
      return p;
   endfunction

endpackage

/* design/ast_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_scan
// Front end: accepts source bytes, runs the scanner and packs the results
// of each byte into one queue entry.
// ----------------------------------------------------------------------------
module ast_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ast_pkg::req_type    req_data,
   input  logic                fifo_full,
   output logic                push_valid,
   output ast_pkg::bundle_type push_data
);
   import ast_pkg::*;

   scan_state_type scan_state_ff, scan_state_in;
   pos_type        line_ff, line_in;
   pos_type        col_ff, col_in;
   pos_type        tok_line_ff, tok_line_in;
   pos_type        tok_col_ff, tok_col_in;

   logic           accept;
   logic           eoi;
   logic [7:0]     c;

   logic           tk_take, tk_emit, tk_end;
   logic [7:0]     tk_byte;
   tok_kind_type   tk_kind;
   scan_state_type tk_next;

   logic           id_emit, id_end;
   tok_kind_type   id_kind;
   scan_state_type id_next;

   pend_info_type  pend;
   logic           any;
   rsp_type        id_res;

   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;
   assign eoi       = req_data.kind == KIND_EOI;
   assign c         = req_data.character;

   // does the byte continue the open token
   always_comb begin
      tk_take = 1'b0;
      tk_emit = 1'b0;
      tk_end  = 1'b0;
      tk_byte = c;
      tk_kind = TK_BAD;
      tk_next = scan_state_ff;
      case (scan_state_ff)
         ST_COMMENT: begin
            tk_take = c != CH_NL;
         end
         ST_DIR_FIRST, ST_REG_FIRST: begin
            if (is_alpha(c)) begin
               tk_take = 1'b1;
               tk_emit = 1'b1;
               tk_next = (scan_state_ff == ST_DIR_FIRST) ? ST_DIR_BODY : ST_REG_BODY;
            end
         end
         ST_DIR_BODY: begin
            tk_take = is_alpha(c) || is_digit(c) || c == CH_USCORE;
            tk_emit = tk_take;
         end
         ST_REG_BODY: begin
            tk_take = is_alpha(c) || is_digit(c);
            tk_emit = tk_take;
         end
         ST_NAME: begin
            if (c == CH_COLON) begin
               tk_take = 1'b1;
               tk_end  = 1'b1;
               tk_kind = TK_LABEL;
               tk_next = ST_IDLE;
            end else begin
               tk_take = is_alpha(c) || is_digit(c) || c == CH_USCORE || c == CH_DOLLAR
                         || c == CH_MINUS;
               tk_emit = tk_take;
            end
         end
         ST_STR: begin
            if (c == CH_QUOTE) begin
               tk_take = 1'b1;
               tk_end  = 1'b1;
               tk_kind = TK_STRING;
               tk_next = ST_IDLE;
            end else if (c == CH_BSLASH) begin
               tk_take = 1'b1;
               tk_next = ST_STR_ESC;
            end else if (c != CH_NL) begin
               tk_take = 1'b1;
               tk_emit = 1'b1;
            end
         end
         ST_STR_ESC: begin
            tk_take = 1'b1;
            tk_emit = 1'b1;
            tk_next = ST_STR;
            if (c == "n") begin
               tk_byte = CH_NL;
            end else if (c == "t") begin
               tk_byte = CH_TAB;
            end else if (c == "r") begin
               tk_byte = CH_CR;
            end else if (c != CH_BSLASH && c != CH_QUOTE) begin
               // unknown escape is swallowed and kills the string
               tk_emit = 1'b0;
               tk_end  = 1'b1;
               tk_next = ST_IDLE;
            end
         end
         ST_IMM_START, ST_OFF_START: begin
            tk_take = 1'b1;
            if (is_digit(c) || c == CH_MINUS) begin
               tk_next = (scan_state_ff == ST_OFF_START) ? ST_OFF_DEC : ST_IMM_DEC;
            end else if (c == "x" || c == "X") begin
               tk_next = (scan_state_ff == ST_OFF_START) ? ST_OFF_HEXS : ST_IMM_HEXS;
            end else if (scan_state_ff == ST_IMM_START && (c == "f" || c == "F")) begin
               tk_next = ST_FLT_SIGN;
            end else begin
               tk_take = 1'b0;
            end
            tk_emit = tk_take;
         end
         ST_IMM_DEC, ST_OFF_DEC: begin
            if (is_digit(c)) begin
               tk_take = 1'b1;
            end else if (c == "u" || c == "U") begin
               tk_take = 1'b1;
               tk_next = (scan_state_ff == ST_OFF_DEC) ? ST_OFF_DONE : ST_IMM_DONE;
            end
            tk_emit = tk_take;
         end
         ST_IMM_HEXS, ST_OFF_HEXS: begin
            if (c == CH_MINUS) begin
               tk_take = 1'b1;
               tk_next = (scan_state_ff == ST_OFF_HEXS) ? ST_OFF_HEXF : ST_IMM_HEXF;
            end else if (is_xdigit(c)) begin
               tk_take = 1'b1;
               tk_next = (scan_state_ff == ST_OFF_HEXS) ? ST_OFF_HEXB : ST_IMM_HEXB;
            end
            tk_emit = tk_take;
         end
         ST_IMM_HEXF, ST_OFF_HEXF: begin
            tk_take = is_xdigit(c);
            tk_emit = tk_take;
            tk_next = (scan_state_ff == ST_OFF_HEXF) ? ST_OFF_HEXB : ST_IMM_HEXB;
         end
         ST_IMM_HEXB, ST_OFF_HEXB: begin
            if (is_xdigit(c)) begin
               tk_take = 1'b1;
            end else if (c == "u" || c == "U") begin
               tk_take = 1'b1;
               tk_next = (scan_state_ff == ST_OFF_HEXB) ? ST_OFF_DONE : ST_IMM_DONE;
            end
            tk_emit = tk_take;
         end
         ST_FLT_SIGN, ST_FLT_FIRST: begin
            tk_take = 1'b1;
            if (c == CH_MINUS && scan_state_ff == ST_FLT_SIGN) begin
               tk_next = ST_FLT_FIRST;
            end else if (is_digit(c)) begin
               tk_next = ST_FLT_INT;
            end else if (c == CH_DOT) begin
               tk_next = ST_FLT_FRAC;
            end else begin
               tk_take = 1'b0;
            end
            tk_emit = tk_take;
         end
         ST_FLT_INT: begin
            tk_take = is_digit(c) || c == CH_DOT;
            tk_emit = tk_take;
            if (c == CH_DOT) begin
               tk_next = ST_FLT_FRAC;
            end
         end
         ST_FLT_FRAC: begin
            tk_take = is_digit(c);
            tk_emit = tk_take;
         end
         default: begin
            tk_take = 1'b0;
         end
      endcase
   end

   // byte seen between tokens
   always_comb begin
      id_emit = 1'b0;
      id_end  = 1'b0;
      id_kind = TK_BAD;
      id_next = ST_IDLE;
      if (is_blank(c)) begin
         id_next = ST_IDLE;
      end else if (c == CH_SEMI) begin
         id_next = ST_COMMENT;
      end else if (c == CH_NL) begin
         id_end  = 1'b1;
         id_kind = TK_NEWLINE;
      end else if (c == CH_LBRK) begin
         id_end  = 1'b1;
         id_kind = TK_LBRACKET;
      end else if (c == CH_RBRK) begin
         id_end  = 1'b1;
         id_kind = TK_RBRACKET;
      end else if (c == CH_COMMA) begin
         id_end  = 1'b1;
         id_kind = TK_COMMA;
      end else if (c == CH_DOT) begin
         id_next = ST_DIR_FIRST;
      end else if (c == CH_PCT) begin
         id_next = ST_REG_FIRST;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         id_emit = 1'b1;
         id_next = ST_OFF_START;
      end else if (c == CH_HASH) begin
         id_next = ST_IMM_START;
      end else if (is_alpha(c) || c == CH_USCORE) begin
         id_emit = 1'b1;
         id_next = ST_NAME;
      end else if (c == CH_QUOTE) begin
         id_next = ST_STR;
      end else begin
         id_end  = 1'b1;
         id_kind = TK_BAD;
      end
   end

   // next state
   always_comb begin
      scan_state_in = scan_state_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      tok_line_in   = tok_line_ff;
      tok_col_in    = tok_col_ff;
      if (accept) begin
         if (eoi) begin
            scan_state_in = ST_IDLE;
            line_in       = POS_ONE;
            col_in        = POS_ONE;
            tok_line_in   = POS_ONE;
            tok_col_in    = POS_ONE;
         end else begin
            if (tk_take) begin
               scan_state_in = tk_next;
            end else begin
               scan_state_in = id_next;
               tok_line_in   = line_ff;
               tok_col_in    = col_ff;
            end
            if (c == CH_NL) begin
               line_in = sat_inc(line_ff);
               col_in  = POS_ONE;
            end else begin
               col_in = sat_inc(col_ff);
            end
         end
      end
   end

   // results of the accepted byte
   always_comb begin
      pend      = pending(scan_state_ff);
      id_res    = id_emit ? mk_byte(c) : mk_end(id_kind, line_ff, col_ff);
      any       = 1'b0;
      push_data = '0;
      if (eoi) begin
         any = 1'b1;
         if (pend.open) begin
            push_data.two    = 1'b1;
            push_data.first  = mk_end(pend.kind, tok_line_ff, tok_col_ff);
            push_data.second = mk_end(TK_END, line_ff, col_ff);
         end else begin
            push_data.first = mk_end(TK_END, line_ff, col_ff);
         end
      end else if (tk_take) begin
         any             = tk_emit || tk_end;
         push_data.first = tk_emit ? mk_byte(tk_byte) : mk_end(tk_kind, tok_line_ff, tok_col_ff);
      end else begin
         any = pend.open || id_emit || id_end;
         if (pend.open) begin
            push_data.first  = mk_end(pend.kind, tok_line_ff, tok_col_ff);
            push_data.two    = id_emit || id_end;
            push_data.second = id_res;
         end else begin
            push_data.first = id_res;
         end
      end
      if (push_data.two) begin
         push_data.second.last = 1'b1;
      end else begin
         push_data.first.last = 1'b1;
      end
      push_valid = accept && any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_state_ff <= ST_IDLE;
         line_ff       <= POS_ONE;
         col_ff        <= POS_ONE;
         tok_line_ff   <= POS_ONE;
         tok_col_ff    <= POS_ONE;
      end else begin
         scan_state_ff <= scan_state_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         tok_line_ff   <= tok_line_in;
         tok_col_ff    <= tok_col_in;
      end
   end

   end_of_input_clears : assert property (@(posedge clock) disable iff (reset)
      accept && eoi |=> scan_state_ff == ST_IDLE && line_ff == POS_ONE && col_ff == POS_ONE)
      else $error("end of input did not clear scanner state");

   newline_restarts_column : assert property (@(posedge clock) disable iff (reset)
      accept && !eoi && c == CH_NL |=> col_ff == POS_ONE)
      else $error("newline did not restart column");

   no_push_into_full : assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !fifo_full)
      else $error("push while queue full");

endmodule

/* design/ast_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_fifo
// Short queue of per-byte result bundles between scanner and output stage.
// ----------------------------------------------------------------------------
module ast_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ast_pkg::bundle_type push_data,
   output logic                full,
   output logic                empty,
   input  logic                pop,
   output ast_pkg::bundle_type head
);
   import ast_pkg::*;

   bundle_type                entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]       count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   count_in_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
      else $error("queue count out of range");

   pointers_track_count : assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[FIFO_PTR_W-1:0])
      else $error("queue pointers disagree with count");

   pop_only_when_filled : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

/* design/ast_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_emit
// Back end: unpacks queued bundles and presents one result per cycle while
// the receiver is ready, through a registered output.
// ----------------------------------------------------------------------------
module ast_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                fifo_empty,
   input  ast_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ast_pkg::rsp_type    rsp_data
);
   import ast_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    sec_valid_ff, sec_valid_in;
   rsp_type sec_ff, sec_in;
   logic    out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = out_free && !sec_valid_ff && !fifo_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      sec_valid_in = sec_valid_ff;
      sec_in       = sec_ff;
      if (out_free) begin
         if (sec_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = sec_ff;
            sec_valid_in = 1'b0;
         end else if (!fifo_empty) begin
            rsp_valid_in = 1'b1;
            rsp_in       = head.first;
            sec_valid_in = head.two;
            sec_in       = head.second;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      sec_ff <= sec_in;
   end

   second_behind_first : assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> rsp_valid_ff && !rsp_ff.last)
      else $error("held second result without a first on display");

   not_last_has_follower : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> sec_valid_ff)
      else $error("non-final result with nothing behind it");

   second_is_last : assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> sec_ff.last)
      else $error("held second result not marked last");

endmodule

/* design/assembly_source_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_core
// Tokenizer for assembly source: one byte per transaction in, value bytes
// and token-end records out.
// ----------------------------------------------------------------------------
//  channel   ports                              carries
//  req       req_valid, req_ready, req_data     source byte or end of input
//  rsp       rsp_valid, rsp_ready, rsp_data     value byte or token end
//
//  A byte is scanned in the cycle it is accepted; one byte per cycle is taken
//  as long as the four-entry result queue has room.
//  Results leave one per cycle from a registered output while rsp_ready is high,
//  so a byte giving two results takes the output twice; the queue absorbs the
//  difference. A byte's first result is registered into the queue, then into
//  the output register.
//  Synchronous reset returns the scanner to idle with line and column at one.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ast_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ast_pkg::rsp_type rsp_data
);
   import ast_pkg::*;

   logic       push_valid;
   bundle_type push_data;
   logic       fifo_full, fifo_empty, pop;
   bundle_type head;

   ast_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .fifo_full  (fifo_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   ast_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (fifo_full),
      .empty      (fifo_empty),
      .pop        (pop),
      .head       (head)
   );

   ast_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/assembly_source_tokenizer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_checker
// Watches both channels of the tokenizer core and runs its own scanner on
// every accepted source transaction. Each result transaction is compared
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ast_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ast_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               outstanding
);
   import ast_pkg::*;

   scan_state_type scan_st;
   pos_type        line_no;
   pos_type        col_no;
   pos_type        tok_line;
   pos_type        tok_col;

   rsp_type step_out [2];
   int      step_n;
   rsp_type expected_results [$];
   int      errors = 0;

   function automatic logic letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic hexnum(logic [7:0] c);
      return numeral(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic spacing(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
   endfunction

   function automatic pos_type bump(pos_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic void reset_scan();
      scan_st  = ST_IDLE;
      line_no  = POS_ONE;
      col_no   = POS_ONE;
      tok_line = POS_ONE;
      tok_col  = POS_ONE;
   endfunction

   function automatic void add_result(logic rk, logic [7:0] vb, tok_kind_type tt,
                                      pos_type ln, pos_type cl);
      rsp_type r;
      r              = '0;
      r.result_kind  = rk;
      r.value_byte   = vb;
      r.token_type   = tt;
      r.start_line   = 16'(ln);
      r.start_column = 16'(cl);
      if (step_n < 2) begin
         step_out[step_n] = r;
         step_n++;
      end
   endfunction

   function automatic void emit_value(logic [7:0] c);
      add_result(RK_BYTE, c, TK_BAD, '0, '0);
   endfunction

   function automatic void close_token(tok_kind_type k);
      add_result(RK_END, 8'h00, k, tok_line, tok_col);
   endfunction

   // what the token in progress would be if it ended on this byte
   function automatic pend_info_type open_token(scan_state_type s);
      pend_info_type p;
      p.open = 1'b1;
      case (s)
         ST_IDLE, ST_COMMENT: begin
            p.open = 1'b0;
            p.kind = TK_BAD;
         end
         ST_DIR_BODY: p.kind = TK_DIRECTIVE;
         ST_REG_BODY: p.kind = TK_REGISTER;
         ST_NAME:     p.kind = TK_IDENT;
         ST_IMM_DEC, ST_IMM_HEXB, ST_IMM_DONE, ST_FLT_INT, ST_FLT_FRAC: p.kind = TK_IMMEDIATE;
         ST_OFF_DEC, ST_OFF_HEXB, ST_OFF_DONE: p.kind = TK_OFFSET;
         default:     p.kind = TK_BAD;
      endcase
      return p;
   endfunction

   function automatic void start_token(logic [7:0] c);
      tok_line = line_no;
      tok_col  = col_no;
      scan_st  = ST_IDLE;
      if (spacing(c)) begin
         return;
      end
      case (c)
         CH_SEMI:  scan_st = ST_COMMENT;
         CH_NL:    close_token(TK_NEWLINE);
         CH_LBRK:  close_token(TK_LBRACKET);
         CH_RBRK:  close_token(TK_RBRACKET);
         CH_COMMA: close_token(TK_COMMA);
         CH_DOT:   scan_st = ST_DIR_FIRST;
         CH_PCT:   scan_st = ST_REG_FIRST;
         CH_PLUS, CH_MINUS: begin
            emit_value(c);
            scan_st = ST_OFF_START;
         end
         CH_HASH:  scan_st = ST_IMM_START;
         CH_QUOTE: scan_st = ST_STR;
         default: begin
            if (letter(c) || c == CH_USCORE) begin
               emit_value(c);
               scan_st = ST_NAME;
            end else begin
               close_token(TK_BAD);
            end
         end
      endcase
   endfunction

   // immediate and offset number bodies
   function automatic logic number_char(logic [7:0] c);
      logic           off;
      scan_state_type nxt;
      off = scan_st >= ST_OFF_START;
      nxt = scan_st;
      case (scan_st)
         ST_IMM_START, ST_OFF_START: begin
            if (numeral(c) || c == CH_MINUS) nxt = off ? ST_OFF_DEC : ST_IMM_DEC;
            else if (c == "x" || c == "X") nxt = off ? ST_OFF_HEXS : ST_IMM_HEXS;
            else if (!off && (c == "f" || c == "F")) nxt = ST_FLT_SIGN;
            else return 1'b0;
         end
         ST_IMM_DEC, ST_OFF_DEC: begin
            if (numeral(c)) nxt = scan_st;
            else if (c == "u" || c == "U") nxt = off ? ST_OFF_DONE : ST_IMM_DONE;
            else return 1'b0;
         end
         ST_IMM_HEXS, ST_OFF_HEXS: begin
            if (c == CH_MINUS) nxt = off ? ST_OFF_HEXF : ST_IMM_HEXF;
            else if (hexnum(c)) nxt = off ? ST_OFF_HEXB : ST_IMM_HEXB;
            else return 1'b0;
         end
         ST_IMM_HEXF, ST_OFF_HEXF: begin
            if (hexnum(c)) nxt = off ? ST_OFF_HEXB : ST_IMM_HEXB;
            else return 1'b0;
         end
         ST_IMM_HEXB, ST_OFF_HEXB: begin
            if (hexnum(c)) nxt = scan_st;
            else if (c == "u" || c == "U") nxt = off ? ST_OFF_DONE : ST_IMM_DONE;
            else return 1'b0;
         end
         default: return 1'b0;
      endcase
      emit_value(c);
      scan_st = nxt;
      return 1'b1;
   endfunction

   // true when the byte belongs to the token or comment in progress
   function automatic logic take_char(logic [7:0] c);
      logic [7:0] d;
      case (scan_st)
         ST_IDLE: return 1'b0;
         ST_COMMENT: return c != CH_NL;
         ST_DIR_FIRST, ST_REG_FIRST: begin
            if (!letter(c)) return 1'b0;
            emit_value(c);
            scan_st = (scan_st == ST_DIR_FIRST) ? ST_DIR_BODY : ST_REG_BODY;
            return 1'b1;
         end
         ST_DIR_BODY: begin
            if (!(letter(c) || numeral(c) || c == CH_USCORE)) return 1'b0;
            emit_value(c);
            return 1'b1;
         end
         ST_REG_BODY: begin
            if (!(letter(c) || numeral(c))) return 1'b0;
            emit_value(c);
            return 1'b1;
         end
         ST_NAME: begin
            if (c == CH_COLON) begin
               close_token(TK_LABEL);
               scan_st = ST_IDLE;
               return 1'b1;
            end
            if (!(letter(c) || numeral(c) || c == CH_USCORE || c == CH_DOLLAR ||
                  c == CH_MINUS)) return 1'b0;
            emit_value(c);
            return 1'b1;
         end
         ST_STR: begin
            if (c == CH_QUOTE) begin
               close_token(TK_STRING);
               scan_st = ST_IDLE;
               return 1'b1;
            end
            if (c == CH_NL) return 1'b0;
            if (c == CH_BSLASH) scan_st = ST_STR_ESC;
            else emit_value(c);
            return 1'b1;
         end
         ST_STR_ESC: begin
            case (c)
               CH_BSLASH, CH_QUOTE: d = c;
               "n":     d = CH_NL;
               "t":     d = CH_TAB;
               "r":     d = CH_CR;
               default: begin
                  // unknown escape is swallowed and kills the string
                  close_token(TK_BAD);
                  scan_st = ST_IDLE;
                  return 1'b1;
               end
            endcase
            emit_value(d);
            scan_st = ST_STR;
            return 1'b1;
         end
         ST_FLT_SIGN, ST_FLT_FIRST: begin
            if (c == CH_MINUS && scan_st == ST_FLT_SIGN) scan_st = ST_FLT_FIRST;
            else if (numeral(c)) scan_st = ST_FLT_INT;
            else if (c == CH_DOT) scan_st = ST_FLT_FRAC;
            else return 1'b0;
            emit_value(c);
            return 1'b1;
         end
         ST_FLT_INT: begin
            if (c == CH_DOT) scan_st = ST_FLT_FRAC;
            else if (!numeral(c)) return 1'b0;
            emit_value(c);
            return 1'b1;
         end
         ST_FLT_FRAC: begin
            if (!numeral(c)) return 1'b0;
            emit_value(c);
            return 1'b1;
         end
         default: return number_char(c);
      endcase
   endfunction

   function automatic void tokenize_item(req_type item);
      pend_info_type pend;
      logic [7:0]    c;
      int            i;
      step_n = 0;
      c      = item.character;
      if (item.kind == KIND_EOI) begin
         pend = open_token(scan_st);
         if (pend.open) close_token(pend.kind);
         add_result(RK_END, 8'h00, TK_END, line_no, col_no);
         reset_scan();
      end else begin
         if (!take_char(c)) begin
            pend = open_token(scan_st);
            if (pend.open) close_token(pend.kind);
            start_token(c);
         end
         if (c == CH_NL) begin
            line_no = bump(line_no);
            col_no  = POS_ONE;
         end else begin
            col_no = bump(col_no);
         end
      end
      for (i = 0; i < step_n; i++) begin
         if (i == step_n - 1) step_out[i].last = 1'b1;
         expected_results.push_back(step_out[i]);
      end
   endfunction

   function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected transaction: result_kind %0h value_byte %0h token_type %0d",
                got.result_kind, got.value_byte, got.token_type);
         errors++;
         return;
      end
      want = expected_results.pop_front();
      field_check("result_kind", 16'(want.result_kind), 16'(got.result_kind));
      field_check("value_byte", 16'(want.value_byte), 16'(got.value_byte));
      field_check("token_type", 16'(want.token_type), 16'(got.token_type));
      field_check("start_line", want.start_line, got.start_line);
      field_check("start_column", want.start_column, got.start_column);
      field_check("last", 16'(want.last), 16'(got.last));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reset_scan();
         expected_results.delete();
      end else begin
         if (req_valid && req_ready) tokenize_item(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
      fail_count  <= errors;
      outstanding <= expected_results.size();
   end

endmodule

/* tb/assembly_source_tokenizer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_core_tb
// Feeds the tokenizer core a short hand-written source, then random token
// fragments (well-formed, broken and noise), draining fully between phases.
// Both channels stall at random; the checker instance does all comparison.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_core_tb;
   import ast_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int RANDOM_ITEMS = 1350;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int   fail_count;
   int   outstanding;
   int   cycles         = 0;
   int   send_idle_pct  = 30;
   int   drain_idle_pct = 30;
   int   stall_left     = 0;
   int   counted        = 0;

   req_type source_q [$];

   string alpha_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string word_set   = "abcdefxyzXYZ0123456789_";
   string ident_set  = "abcdefxyzXYZ0123456789_$-";
   string hex_set    = "0123456789abcdefABCDEF";
   string digit_set  = "0123456789";
   string text_set   = "abcXYZ0189 ,.;:#%[]+-_'";
   string escape_set = "\\\"ntr";

   assembly_source_tokenizer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assembly_source_tokenizer_checker token_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < drain_idle_pct) stall_left = gap_len();
      end
   end

   task automatic send_item(input req_type item);
      int gap;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = gap_len();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_char(input logic [7:0] c);
      send_item({KIND_CHAR, c});
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_eoi();
      send_item({KIND_EOI, 8'($urandom_range(0, 255))});
   endtask

   // hold off until the checker has nothing outstanding
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 4))
         0:       return CH_TAB;
         1:       return CH_VT;
         2:       return CH_FF;
         3:       return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic void put_char(logic [7:0] c);
      source_q.push_back({KIND_CHAR, c});
   endfunction

   function automatic void put_digits(string s);
      int n;
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      repeat (n) put_char(pick(s));
   endfunction

   function automatic void put_number(logic imm);
      case ($urandom_range(0, imm ? 4 : 3))
         0, 1: begin
            if ($urandom_range(0, 9) < 2) put_char(CH_MINUS);
            put_digits(digit_set);
            if ($urandom_range(0, 3) == 0) put_char(pick("uU"));
         end
         2: begin
            put_char(pick("xX"));
            if ($urandom_range(0, 9) < 2) put_char(CH_MINUS);
            put_digits(hex_set);
            if ($urandom_range(0, 3) == 0) put_char(pick("uU"));
         end
         3: begin
            // missing number body
            if ($urandom_range(0, 1) != 0) put_char(pick(alpha_set));
         end
         default: begin
            put_char(pick("fF"));
            if ($urandom_range(0, 9) < 3) put_char(CH_MINUS);
            repeat ($urandom_range(0, 3)) put_char(pick(digit_set));
            if ($urandom_range(0, 9) < 6) begin
               put_char(CH_DOT);
               repeat ($urandom_range(0, 3)) put_char(pick(digit_set));
            end
         end
      endcase
   endfunction

   function automatic void put_name(logic wide);
      put_char(($urandom_range(0, 7) == 0) ? CH_USCORE : pick(alpha_set));
      repeat ($urandom_range(0, 5)) put_char(pick(wide ? ident_set : word_set));
   endfunction

   function automatic void put_string();
      int r;
      put_char(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         r = $urandom_range(0, 9);
         if (r < 5) begin
            put_char(pick(text_set));
         end else if (r == 5) begin
            put_char(8'($urandom_range(128, 255)));
         end else if (r < 9) begin
            put_char(CH_BSLASH);
            put_char(pick(escape_set));
         end else begin
            put_char(CH_BSLASH);
            put_char(pick(alpha_set));
         end
      end
      r = $urandom_range(0, 9);
      if (r < 8) put_char(CH_QUOTE);
      else if (r == 8) put_char(CH_NL);
   endfunction

   function automatic void build_fragment();
      logic [7:0] b;
      int         r;
      case ($urandom_range(0, 19))
         0, 1: begin
            put_char(CH_DOT);
            if ($urandom_range(0, 9) != 0) put_char(pick(alpha_set));
            repeat ($urandom_range(0, 5)) put_char(pick(word_set));
         end
         2, 3: begin
            put_char(CH_PCT);
            if ($urandom_range(0, 9) != 0) put_char(pick(alpha_set));
            repeat ($urandom_range(0, 4)) put_char(pick(word_set));
         end
         4, 5: begin
            put_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            put_number(1'b0);
         end
         6, 7: begin
            put_char(CH_HASH);
            put_number(1'b1);
         end
         8: begin
            put_name(1'b0);
            put_char(CH_COLON);
         end
         9, 10: put_name(1'b1);
         11, 12: put_string();
         13: put_char($urandom_range(0, 1) ? CH_LBRK : CH_RBRK);
         14: put_char(CH_COMMA);
         15: put_char(CH_NL);
         16: begin
            put_char(CH_SEMI);
            repeat ($urandom_range(0, 6)) begin
               b = 8'($urandom_range(0, 255));
               put_char((b == CH_NL) ? CH_SPACE : b);
            end
            put_char(CH_NL);
         end
         17: repeat ($urandom_range(1, 3)) put_char(blank_char());
         18: put_char(8'($urandom_range(0, 255)));
         default: begin
            if ($urandom_range(0, 1) != 0) begin
               source_q.push_back({KIND_EOI, 8'($urandom_range(0, 255))});
            end else begin
               put_char(8'($urandom_range(0, 255)));
            end
         end
      endcase
      r = $urandom_range(0, 9);
      if (r < 4) put_char(CH_SPACE);
      else if (r == 4) put_char(blank_char());
      else if (r == 5) put_char(CH_COMMA);
      else if (r == 6) put_char(CH_NL);
   endfunction

   task automatic run_random(input int goal);
      req_type item;
      while (counted < goal) begin
         if ($urandom_range(0, 39) == 0) begin
            case ($urandom_range(0, 3))
               0:       send_idle_pct <= 0;
               1:       send_idle_pct <= 10;
               2:       send_idle_pct <= 35;
               default: send_idle_pct <= 70;
            endcase
            case ($urandom_range(0, 3))
               0:       drain_idle_pct <= 0;
               1:       drain_idle_pct <= 10;
               2:       drain_idle_pct <= 35;
               default: drain_idle_pct <= 70;
            endcase
         end
         if ($urandom_range(0, 149) == 0) wait_drained();
         build_fragment();
         while (source_q.size() != 0) begin
            item = source_q.pop_front();
            counted++;
            send_item(item);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hand-written opening: byte extremes, every token class but a closed string, broken tokens
      send_char(8'h00);
      send_char(8'hFF);
      send_text(".a%r+1,");
      send_text("%1");
      send_text("x:y");
      send_text("\"\\q");
      send_text("\"a\n");
      send_text("[#5]");
      send_text(";c\n");
      send_eoi();
      wait_drained();

      run_random(RANDOM_ITEMS / 2);
      wait_drained();

      run_random(RANDOM_ITEMS);
      wait_drained();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
